// ===== src/homogeneous_point_transform_macros.svh =====
// Assertion macros used by the point transform top level.
`ifndef HOMOGENEOUS_POINT_TRANSFORM_MACROS_SVH
`define HOMOGENEOUS_POINT_TRANSFORM_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define HPT_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("hpt same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define HPT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("hpt next-cycle check failed");

`endif

// ===== src/hpt_pkg.sv =====
// Types and constants of the homogeneous point transform.
package hpt_pkg;

    localparam int COORD_W  = 32;
    localparam int COEF_W   = 16;
    localparam int PROD_W   = 48;
    localparam int ACC_W    = 50;
    localparam int FRAC_SH  = 12;
    localparam int ONE_SH   = 16;
    localparam int ROW_W    = 38;
    localparam int MAG_W    = 38;
    localparam int NUM_W    = 54;
    localparam int Q_W      = 32;
    localparam int ROW_LAT  = 2;
    localparam int DIV_LAT  = Q_W + 2;
    localparam int PIPE_LAT = ROW_LAT + DIV_LAT;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_ROW0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW3 = 3'd3;

    localparam logic [CFG_DATA_W-1:0] ROW0_RESET = 64'h0000_0000_0000_1000;
    localparam logic [CFG_DATA_W-1:0] ROW1_RESET = 64'h0000_0000_1000_0000;
    localparam logic [CFG_DATA_W-1:0] ROW2_RESET = 64'h0000_1000_0000_0000;
    localparam logic [CFG_DATA_W-1:0] ROW3_RESET = 64'h1000_0000_0000_0000;

    typedef struct packed {
        logic signed [COORD_W-1:0] in_x;
        logic signed [COORD_W-1:0] in_y;
        logic signed [COORD_W-1:0] in_z;
    } t_in;

    typedef struct packed {
        logic signed [COORD_W-1:0] out_x;
        logic signed [COORD_W-1:0] out_y;
        logic signed [COORD_W-1:0] out_z;
        logic                      w_was_zero;
        logic                      saturated;
    } t_out;

    typedef struct packed {
        logic [NUM_W-1:0] num;
        logic [MAG_W-1:0] den;
        logic             neg;
    } t_div_req;

endpackage

// ===== src/hpt_row.sv =====
// One matrix row: products in the first stage, sum in the second.
module hpt_row
    import hpt_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic [CFG_DATA_W-1:0]   i_row,
    input  t_in                     i_pt,
    output logic signed [ROW_W-1:0] o_val
);

    logic signed [COEF_W-1:0] c0, c1, c2, c3;
    logic signed [PROD_W-1:0] n_p0, n_p1, n_p2;
    logic signed [ACC_W-1:0]  n_tr, n_sum;
    logic signed [PROD_W-1:0] r_p0, r_p1, r_p2;
    logic signed [ACC_W-1:0]  r_tr, r_sum;

    assign c0 = i_row[15:0];
    assign c1 = i_row[31:16];
    assign c2 = i_row[47:32];
    assign c3 = i_row[63:48];

    assign n_p0 = PROD_W'(c0) * PROD_W'(i_pt.in_x);
    assign n_p1 = PROD_W'(c1) * PROD_W'(i_pt.in_y);
    assign n_p2 = PROD_W'(c2) * PROD_W'(i_pt.in_z);
    assign n_tr = ACC_W'(c3) <<< ONE_SH;

    assign n_sum = ACC_W'(r_p0) + ACC_W'(r_p1) + ACC_W'(r_p2) + r_tr;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p0  <= n_p0;
            r_p1  <= n_p1;
            r_p2  <= n_p2;
            r_tr  <= n_tr;
            r_sum <= n_sum;
        end
    end

    // An arithmetic shift floors towards minus infinity.
    assign o_val = ROW_W'(r_sum >>> FRAC_SH);

endmodule

// ===== src/hpt_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with signed clamp.
module hpt_div
    import hpt_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_en,
    input  t_div_req                  i_req,
    output logic signed [Q_W-1:0]     o_q,
    output logic                      o_sat
);

    logic [MAG_W-1:0] r_rem [0:Q_W];
    logic [Q_W-1:0]   r_low [0:Q_W];
    logic [Q_W-1:0]   r_q   [0:Q_W];
    logic [MAG_W-1:0] r_den [0:Q_W];
    logic             r_neg [0:Q_W];
    logic             r_ovf [0:Q_W];
    logic [Q_W-1:0]   q;
    logic             n_sat;
    logic [Q_W-1:0]   n_q;

    // A quotient of 2^32 or more shows up as the top part not below the divisor.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= MAG_W'(i_req.num[NUM_W-1:Q_W]);
            r_low[0] <= i_req.num[Q_W-1:0];
            r_q[0]   <= '0;
            r_den[0] <= i_req.den;
            r_neg[0] <= i_req.neg;
            r_ovf[0] <= MAG_W'(i_req.num[NUM_W-1:Q_W]) >= i_req.den;
        end
    end

    for (genvar k = 1; k <= Q_W; k++) begin : g_step
        logic [MAG_W:0] t;
        logic           ge;
        assign t  = {r_rem[k-1], r_low[k-1][Q_W-1]};
        assign ge = t >= {1'b0, r_den[k-1]};
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= ge ? MAG_W'(t - {1'b0, r_den[k-1]}) : MAG_W'(t);
                r_low[k] <= {r_low[k-1][Q_W-2:0], 1'b0};
                r_q[k]   <= {r_q[k-1][Q_W-2:0], ge};
                r_den[k] <= r_den[k-1];
                r_neg[k] <= r_neg[k-1];
                r_ovf[k] <= r_ovf[k-1];
            end
        end
    end

    assign q = r_q[Q_W];

    always_comb begin
        n_sat = r_ovf[Q_W];
        n_q   = '0;
        if (r_neg[Q_W]) begin
            if (n_sat || q > {1'b1, {(Q_W-1){1'b0}}}) begin
                n_sat = 1'b1;
                n_q   = {1'b1, {(Q_W-1){1'b0}}};
            end else begin
                n_q = ~q + 1'b1;
            end
        end else begin
            if (n_sat || q[Q_W-1]) begin
                n_sat = 1'b1;
                n_q   = {1'b0, {(Q_W-1){1'b1}}};
            end else begin
                n_q = q;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_q   <= n_q;
            o_sat <= n_sat;
        end
    end

endmodule

// ===== src/homogeneous_point_transform.sv =====
// Top level of the homogeneous point transform with perspective divide.
// Input channel: i_valid, o_stall, i_payload (x, y, z in signed Q16.16). A request
// is taken at a clock edge with i_valid high and o_stall low.
// Output channel: o_valid, i_stall, o_payload (x, y, z divided by w, plus the
// w_was_zero and saturated flags). A result is taken when o_valid is high and
// i_stall is low.
// Configuration: i_cfg_valid, o_cfg_ready (always high), i_cfg_index, i_cfg_data.
// Indices 0 to 3 load matrix rows 0 to 3; other indices are ignored.
// A request passes first through the product and sum registers of the row units,
// then through three parallel dividers that retire one quotient bit per stage.
// Throughput is one point per cycle while the receiver does not stall.
// Reset clears every valid bit and loads the identity matrix.
// When the receiver stalls a waiting result, the whole pipeline freezes and
// o_stall is raised towards the sender; nothing is dropped or repeated.
module homogeneous_point_transform
    import hpt_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  t_in                   i_payload,
    output logic                  o_valid,
    input  logic                  i_stall,
    output t_out                  o_payload,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    `include "homogeneous_point_transform_macros.svh"

    logic [CFG_DATA_W-1:0] r_row [0:3];
    logic [PIPE_LAT-1:0]   r_vld;
    logic [DIV_LAT-1:0]    r_wz;
    logic                  en;
    logic signed [ROW_W-1:0] vx, vy, vz, vw;
    logic [MAG_W-1:0]      mx, my, mz, mw;
    logic                  wz;
    t_div_req              req_x, req_y, req_z;
    logic                  sat_x, sat_y, sat_z;

    assign o_cfg_ready = 1'b1;
    assign o_stall     = r_vld[PIPE_LAT-1] & i_stall;
    assign en          = ~o_stall;
    assign o_valid     = r_vld[PIPE_LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row[0] <= ROW0_RESET;
            r_row[1] <= ROW1_RESET;
            r_row[2] <= ROW2_RESET;
            r_row[3] <= ROW3_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_ROW0: r_row[0] <= i_cfg_data;
                CFG_ROW1: r_row[1] <= i_cfg_data;
                CFG_ROW2: r_row[2] <= i_cfg_data;
                CFG_ROW3: r_row[3] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[PIPE_LAT-2:0], i_valid};
        end
    end

    hpt_row u_row_x (.i_clk(i_clk), .i_en(en), .i_row(r_row[0]), .i_pt(i_payload), .o_val(vx));
    hpt_row u_row_y (.i_clk(i_clk), .i_en(en), .i_row(r_row[1]), .i_pt(i_payload), .o_val(vy));
    hpt_row u_row_z (.i_clk(i_clk), .i_en(en), .i_row(r_row[2]), .i_pt(i_payload), .o_val(vz));
    hpt_row u_row_w (.i_clk(i_clk), .i_en(en), .i_row(r_row[3]), .i_pt(i_payload), .o_val(vw));

    assign mx = MAG_W'(vx[ROW_W-1] ? -vx : vx);
    assign my = MAG_W'(vy[ROW_W-1] ? -vy : vy);
    assign mz = MAG_W'(vz[ROW_W-1] ? -vz : vz);
    assign mw = MAG_W'(vw[ROW_W-1] ? -vw : vw);
    assign wz = (vw == '0);

    // With w zero the row value is divided by one, which leaves only the clamp.
    always_comb begin
        req_x.num = wz ? NUM_W'(mx) : {mx, {ONE_SH{1'b0}}};
        req_y.num = wz ? NUM_W'(my) : {my, {ONE_SH{1'b0}}};
        req_z.num = wz ? NUM_W'(mz) : {mz, {ONE_SH{1'b0}}};
        req_x.den = wz ? MAG_W'(1) : mw;
        req_y.den = req_x.den;
        req_z.den = req_x.den;
        req_x.neg = vx[ROW_W-1] ^ (~wz & vw[ROW_W-1]);
        req_y.neg = vy[ROW_W-1] ^ (~wz & vw[ROW_W-1]);
        req_z.neg = vz[ROW_W-1] ^ (~wz & vw[ROW_W-1]);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_wz <= {r_wz[DIV_LAT-2:0], wz};
        end
    end

    hpt_div u_div_x (.i_clk(i_clk), .i_en(en), .i_req(req_x), .o_q(o_payload.out_x),
                     .o_sat(sat_x));
    hpt_div u_div_y (.i_clk(i_clk), .i_en(en), .i_req(req_y), .o_q(o_payload.out_y),
                     .o_sat(sat_y));
    hpt_div u_div_z (.i_clk(i_clk), .i_en(en), .i_req(req_z), .o_q(o_payload.out_z),
                     .o_sat(sat_z));

    assign o_payload.w_was_zero = r_wz[DIV_LAT-1];
    assign o_payload.saturated  = sat_x | sat_y | sat_z;

    `HPT_ASSERT_NOW(a_stall_only_on_result, o_stall, o_valid)
    `HPT_ASSERT_NEXT(a_stall_freezes_pipe, o_stall, $stable(r_vld))
    `HPT_ASSERT_NEXT(a_request_enters, i_valid && !o_stall, r_vld[0])

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the homogeneous point transform.
`timescale 1ns / 1ps

module tb;
    import hpt_pkg::*;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_stall;
    t_in                   i_payload;
    logic                  o_valid;
    logic                  i_stall;
    t_out                  o_payload;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    localparam int DRAIN_CYCLES = PIPE_LAT + 20;
    localparam longint CYCLE_LIMIT = 2_000_000;

    logic [CFG_DATA_W-1:0] matrix_rows [4];
    t_out    expected_points [$];
    int      error_count;
    int      results_seen;
    int      points_sent;
    int      wzero_seen;
    int      sat_seen;
    longint  cycle_count;
    bit      sink_idle_on;
    bit      hold_sink;
    int      hold_cycles;

    homogeneous_point_transform u_top (.*);

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Row value in Q16.16 after flooring the Q.28 sum.
    function automatic longint row_q16(logic [CFG_DATA_W-1:0] row, longint x, longint y,
                                       longint z);
        longint acc;
        longint c [4];
        for (int j = 0; j < 4; j++) c[j] = longint'($signed(row[16*j +: 16]));
        acc = c[0] * x + c[1] * y + c[2] * z + c[3] * 65536;
        return acc >>> 12;
    endfunction

    function automatic logic [31:0] clamp_q16(longint v, ref bit sat);
        if (v > 64'sd2147483647) begin
            sat = 1'b1;
            return 32'h7fff_ffff;
        end
        if (v < -64'sd2147483648) begin
            sat = 1'b1;
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

    function automatic t_out project_point(t_in p);
        t_out   r;
        longint v [4];
        bit     sat;
        sat = 1'b0;
        for (int i = 0; i < 4; i++)
            v[i] = row_q16(matrix_rows[i], longint'(p.in_x), longint'(p.in_y),
                           longint'(p.in_z));
        r.w_was_zero = (v[3] == 0);
        if (v[3] != 0)
            for (int i = 0; i < 3; i++) v[i] = (v[i] * 65536) / v[3];
        r.out_x = clamp_q16(v[0], sat);
        r.out_y = clamp_q16(v[1], sat);
        r.out_z = clamp_q16(v[2], sat);
        r.saturated = sat;
        return r;
    endfunction

    task automatic idle_gap();
        repeat ($urandom_range(1, 12)) @(posedge i_clk);
    endtask

    // The valid line stays high between requests; it drops only for a gap or a drain.
    task automatic send_point(t_in p, bit gaps);
        if (gaps && $urandom_range(0, 5) == 0) begin
            i_valid <= 1'b0;
            idle_gap();
        end
        i_valid   <= 1'b1;
        i_payload <= p;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        expected_points.push_back(project_point(p));
        points_sent++;
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (expected_points.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (idx <= CFG_ROW3) matrix_rows[idx] = val;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [31:0] edge_coord();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h0;
            3: return 32'h0001_0000;
            4: return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    function automatic t_in random_point(bit small_range);
        t_in p;
        if (small_range) begin
            p.in_x = $signed($urandom_range(0, 32'h00ff_ffff)) - 32'sh0080_0000;
            p.in_y = $signed($urandom_range(0, 32'h00ff_ffff)) - 32'sh0080_0000;
            p.in_z = $signed($urandom_range(0, 32'h00ff_ffff)) - 32'sh0080_0000;
        end else begin
            p.in_x = edge_coord();
            p.in_y = edge_coord();
            p.in_z = edge_coord();
        end
        return p;
    endfunction

    function automatic logic [15:0] random_coef();
        case ($urandom_range(0, 6))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0;
            3: return 16'h1000;
            4: return 16'hf000;
            default: return $urandom;
        endcase
    endfunction

    task automatic test_identity();
        t_in p;
        p = '{32'h7fff_ffff, 32'h8000_0000, 32'h0};
        send_point(p, 0);
        p = '{32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff};
        send_point(p, 0);
        p = '{32'h0001_0000, 32'hfffe_0000, 32'h0003_8000};
        send_point(p, 0);
        p = '{32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff};
        send_point(p, 0);
        wait_drained();
    endtask

    task automatic test_zero_w();
        t_in p;
        // Last row all zero, so w is zero and the point passes undivided.
        write_row(CFG_ROW3, 64'h0);
        write_row(CFG_ROW0, 64'h7fff_7fff_7fff_7fff);
        p = '{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff};
        send_point(p, 0);
        p = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
        send_point(p, 0);
        wait_drained();
        // Zero w again with extreme coefficients in row 0, so the undivided x saturates.
        write_row(CFG_ROW3, 64'h0);
        write_row(CFG_ROW0, 64'h8000_8000_8000_8000);
        write_row(CFG_ROW1, 64'h7fff_0000_0000_0000);
        write_row(CFG_ROW2, 64'h0000_0000_0000_0001);
        p = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
        send_point(p, 0);
        p = '{32'h7fff_ffff, 32'h0, 32'h0};
        send_point(p, 0);
        wait_drained();
        write_row(3'd5, 64'hffff_ffff_ffff_ffff);
        write_row(3'd7, 64'h0);
        write_row(CFG_ROW3, 64'hffff_0000_0000_0001);
        p = '{32'h0, 32'h0, 32'h0};
        send_point(p, 0);
        p = '{32'h0000_1000, 32'hffff_f000, 32'h8000_0000};
        send_point(p, 0);
        wait_drained();
    endtask

    task automatic test_random_matrices(int phases, int per_phase, bit gaps);
        logic [CFG_DATA_W-1:0] row;
        for (int ph = 0; ph < phases; ph++) begin
            for (int r = 0; r < 4; r++) begin
                row = {random_coef(), random_coef(), random_coef(), random_coef()};
                write_row(r[CFG_IDX_W-1:0], row);
            end
            // Keep w well defined most of the time with a sizeable translation.
            if ($urandom_range(0, 2) != 0)
                write_row(CFG_ROW3, {16'h1000 + 16'($urandom_range(0, 255)), 48'h0});
            for (int i = 0; i < per_phase; i++)
                send_point(random_point($urandom_range(0, 3) != 0), gaps);
            wait_drained();
        end
    endtask

    task automatic test_backpressure();
        hold_cycles = 150;
        hold_sink   = 1'b1;
        for (int i = 0; i < 60; i++) send_point(random_point(1'b1), 0);
        wait_drained();
    endtask

    // Result checker and receiver idling.
    always @(posedge i_clk) begin
        t_out exp_pt;
        if (i_rst_n) begin
            cycle_count <= cycle_count + 1;
            if (o_valid && !i_stall) begin
                if (expected_points.size() == 0) begin
                    $error("result with nothing expected: %h", o_payload);
                    error_count++;
                end else begin
                    exp_pt = expected_points.pop_front();
                    results_seen++;
                    if (exp_pt.w_was_zero) wzero_seen++;
                    if (exp_pt.saturated) sat_seen++;
                    if (o_payload.out_x !== exp_pt.out_x) begin
                        $error("out_x expected %h got %h", exp_pt.out_x, o_payload.out_x);
                        error_count++;
                    end
                    if (o_payload.out_y !== exp_pt.out_y) begin
                        $error("out_y expected %h got %h", exp_pt.out_y, o_payload.out_y);
                        error_count++;
                    end
                    if (o_payload.out_z !== exp_pt.out_z) begin
                        $error("out_z expected %h got %h", exp_pt.out_z, o_payload.out_z);
                        error_count++;
                    end
                    if (o_payload.w_was_zero !== exp_pt.w_was_zero) begin
                        $error("w_was_zero expected %b got %b", exp_pt.w_was_zero,
                               o_payload.w_was_zero);
                        error_count++;
                    end
                    if (o_payload.saturated !== exp_pt.saturated) begin
                        $error("saturated expected %b got %b", exp_pt.saturated,
                               o_payload.saturated);
                        error_count++;
                    end
                end
            end
        end
    end

    initial begin : sink_idle
        int n;
        forever begin
            @(posedge i_clk);
            if (hold_sink) begin
                i_stall <= 1'b1;
                repeat (hold_cycles) @(posedge i_clk);
                hold_sink = 1'b0;
                i_stall <= 1'b0;
            end else if (sink_idle_on && $urandom_range(0, 5) == 0) begin
                n = $urandom_range(1, 12);
                i_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    initial begin : watchdog
        wait (cycle_count > CYCLE_LIMIT);
        $display("timeout after %0d cycles", cycle_count);
        $display("FAILURE");
        $finish;
    end

    initial begin
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_stall     = 1'b0;
        i_payload   = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        error_count = 0;
        results_seen = 0;
        points_sent = 0;
        wzero_seen = 0;
        sat_seen = 0;
        cycle_count = 0;
        sink_idle_on = 1'b0;
        hold_sink = 1'b0;
        hold_cycles = 0;
        matrix_rows[0] = ROW0_RESET;
        matrix_rows[1] = ROW1_RESET;
        matrix_rows[2] = ROW2_RESET;
        matrix_rows[3] = ROW3_RESET;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_identity();
        test_zero_w();
        sink_idle_on = 1'b1;
        test_backpressure();
        test_random_matrices(25, 50, 1);
        sink_idle_on = 1'b0;
        test_random_matrices(8, 50, 0);
        wait_drained();

        $display("Sent %0d points through %0d matrix settings; %0d results checked,",
                 points_sent, 36, results_seen);
        $display("%0d with zero w and %0d saturated.", wzero_seen, sat_seen);
        if (error_count == 0 && expected_points.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
